@@ src/b2d_pkg.sv @@
package b2d_pkg;

  localparam int DIGIT_BITS = 4;
  localparam int RADIX = 10;
  localparam int CHAR_BITS = 6;
  localparam logic [CHAR_BITS-1:0] ASCII_ZERO = 6'd48;
  localparam logic [DIGIT_BITS-1:0] ADJ_LIMIT = DIGIT_BITS'(RADIX / 2);
  localparam logic [DIGIT_BITS-1:0] ADJ_ADD = 4'd3;
  localparam int LOG10_2_NUM = 1233;
  localparam int LOG10_2_SHIFT = 12;

  typedef struct packed {
    logic load;
    logic shift;
    logic drop;
  } b2d_cmd_t;

  typedef struct packed {
    logic conv_done;
    logic top_zero;
    logic one_left;
  } b2d_sts_t;

endpackage

@@ src/b2d_if.sv @@
interface b2d_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

interface b2d_out_if;
  logic       valid;
  logic       ready;
  logic [5:0] ascii_char;
  logic       last_digit;

  modport source (output valid, output ascii_char, output last_digit, input ready);
  modport sink (input valid, input ascii_char, input last_digit, output ready);
endinterface

@@ src/binary_to_decimal_ascii.sv @@
// Binary to decimal ASCII converter. Each value transfer on din is printed as
// decimal ASCII digits on dout, most significant first, leading zeros removed
// (zero prints as a single '0'); last_digit marks the final digit of the run.
// Only the low VALUE_BITS bits of value are converted. One value is handled
// at a time: the shift-and-add-3 converter takes one input bit per cycle,
// then leading zeros are dropped one digit at a time and the digits are
// sent. din is not ready until the last digit of the previous run has been
// transferred.
module binary_to_decimal_ascii #(
  parameter int VALUE_BITS = 32
) (
  input logic clk,
  input logic rst,
  b2d_in_if.sink    din,
  b2d_out_if.source dout
);
  import b2d_pkg::*;

  localparam int DIGITS = ((VALUE_BITS * LOG10_2_NUM) >> LOG10_2_SHIFT) + 1;

  b2d_cmd_t cmd;
  b2d_sts_t sts;

  b2d_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (din.valid),
    .in_ready  (din.ready),
    .out_valid (dout.valid),
    .out_ready (dout.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  b2d_datapath #(
    .VALUE_BITS (VALUE_BITS),
    .DIGITS     (DIGITS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .value      (din.value),
    .cmd        (cmd),
    .sts        (sts),
    .ascii_char (dout.ascii_char),
    .last_digit (dout.last_digit)
  );

endmodule

@@ src/b2d_datapath.sv @@
module b2d_datapath #(
  parameter int VALUE_BITS = 32,
  parameter int DIGITS = 10
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [31:0]         value,
  input  b2d_pkg::b2d_cmd_t   cmd,
  output b2d_pkg::b2d_sts_t   sts,
  output logic [5:0]          ascii_char,
  output logic                last_digit
);
  import b2d_pkg::*;

  localparam int BCD_W = DIGIT_BITS * DIGITS;
  localparam int CNT_W = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
  localparam int DCNT_W = $clog2(DIGITS + 1);

  logic [VALUE_BITS-1:0] bin;
  logic [BCD_W-1:0]      bcd;
  logic [BCD_W-1:0]      adj;
  logic [CNT_W-1:0]      cnt;
  logic [DCNT_W-1:0]     dcnt;
  logic [DIGIT_BITS-1:0] top;

  // add-3 correction ahead of each shift
  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      if (bcd[i*DIGIT_BITS +: DIGIT_BITS] >= ADJ_LIMIT) begin
        adj[i*DIGIT_BITS +: DIGIT_BITS] = bcd[i*DIGIT_BITS +: DIGIT_BITS] + ADJ_ADD;
      end else begin
        adj[i*DIGIT_BITS +: DIGIT_BITS] = bcd[i*DIGIT_BITS +: DIGIT_BITS];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      bin <= value[VALUE_BITS-1:0];
      bcd <= '0;
    end else if (cmd.shift) begin
      bin <= {bin[VALUE_BITS-2:0], 1'b0};
      bcd <= {adj[BCD_W-2:0], bin[VALUE_BITS-1]};
    end else if (cmd.drop) begin
      bcd <= {bcd[BCD_W-DIGIT_BITS-1:0], {DIGIT_BITS{1'b0}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      dcnt <= '0;
    end else if (cmd.load) begin
      cnt  <= '0;
      dcnt <= DCNT_W'(DIGITS);
    end else begin
      if (cmd.shift) begin
        cnt <= cnt + 1'b1;
      end
      if (cmd.drop) begin
        dcnt <= dcnt - 1'b1;
      end
    end
  end

  assign top = bcd[BCD_W-1 -: DIGIT_BITS];

  assign sts.conv_done = (cnt == CNT_W'(VALUE_BITS - 1));
  assign sts.top_zero  = (top == '0);
  assign sts.one_left  = (dcnt == DCNT_W'(1));

  assign ascii_char = CHAR_BITS'(top) + ASCII_ZERO;
  assign last_digit = sts.one_left;

endmodule

@@ src/b2d_ctrl.sv @@
module b2d_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  b2d_pkg::b2d_sts_t sts,
  output b2d_pkg::b2d_cmd_t cmd
);
  import b2d_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CONV = 4'b0010,
    S_SKIP = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CONV;
        end
      end
      S_CONV: begin
        cmd.shift = 1'b1;
        if (sts.conv_done) begin
          state_next = S_SKIP;
        end
      end
      S_SKIP: begin
        // strip leading zeros, always keep the final digit
        if (sts.top_zero && !sts.one_left) begin
          cmd.drop = 1'b1;
        end else begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (sts.one_left) begin
            state_next = S_IDLE;
          end else begin
            cmd.drop = 1'b1;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input and output active together");

  a_load_starts: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (state == S_CONV))
    else $error("load did not start conversion");

  a_cmd_excl: assert property (@(posedge clk) disable iff (rst)
    !(cmd.shift && cmd.drop) && !(cmd.load && (cmd.shift || cmd.drop)))
    else $error("conflicting datapath commands");

  a_run_end: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && sts.one_left) |=> (state == S_IDLE))
    else $error("run did not end after last transfer");

endmodule

@@ tb/decimal_digit_checker.sv @@
module decimal_digit_checker #(
  parameter int VALUE_BITS = 32
) (
  input  logic      clk,
  input  logic      rst,
  b2d_in_if         din,
  b2d_out_if        dout,
  output int        fail_count,
  output int        pending_digits,
  output int        values_seen,
  output int        digits_seen,
  output int        full_runs
);
  import b2d_pkg::*;

  localparam int MAX_DIGITS = 10;

  typedef struct packed {
    logic [CHAR_BITS-1:0] ascii_char;
    logic                 last_digit;
  } digit_t;

  digit_t expected_digits[$];

  initial begin
    fail_count = 0;
    values_seen = 0;
    digits_seen = 0;
    full_runs = 0;
    pending_digits = 0;
  end

  // queue the decimal digits of one value, most significant first
  function automatic void predict_decimal(input logic [31:0] value);
    logic [31:0]           rest;
    logic [DIGIT_BITS-1:0] rev [MAX_DIGITS];
    int                    n;
    rest = value;
    n = 0;
    for (int b = VALUE_BITS; b < 32; b++) rest[b] = 1'b0;
    do begin
      rev[n] = DIGIT_BITS'(rest % RADIX);
      rest = rest / RADIX;
      n++;
    end while (rest != 0 && n < MAX_DIGITS);
    for (int k = n - 1; k >= 0; k--) begin
      expected_digits.push_back('{ascii_char: ASCII_ZERO + CHAR_BITS'(rev[k]),
                                  last_digit: (k == 0)});
    end
    if (n == MAX_DIGITS) full_runs++;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] dout mismatch: %s", $time, msg);
    fail_count++;
  endtask

  always @(posedge clk) begin
    digit_t want;
    if (!rst) begin
      if (din.valid && din.ready) begin
        predict_decimal(din.value);
        values_seen++;
      end
      if (dout.valid && dout.ready) begin
        digits_seen++;
        if (expected_digits.size() == 0) begin
          report_mismatch($sformatf("unexpected transfer char %0d last %0b",
                                    dout.ascii_char, dout.last_digit));
        end else begin
          want = expected_digits.pop_front();
          if (dout.ascii_char !== want.ascii_char)
            report_mismatch($sformatf("ascii_char %0d, want %0d",
                                      dout.ascii_char, want.ascii_char));
          if (dout.last_digit !== want.last_digit)
            report_mismatch($sformatf("last_digit %0b, want %0b (char %0d)",
                                      dout.last_digit, want.last_digit, want.ascii_char));
        end
      end
    end
    pending_digits <= expected_digits.size();
  end

endmodule

@@ tb/binary_to_decimal_ascii_tb.sv @@
module binary_to_decimal_ascii_tb;
  import b2d_pkg::*;

  localparam int VALUE_BITS = 32;
  localparam int RANDOM_ITEMS = 290;
  localparam int QUIET_ITEMS = 40;
  localparam int LONG_HOLD = 400;
  localparam int DRAIN_CYCLES = 60;
  localparam int WATCHDOG_LIMIT = 2000;

  logic clk = 1'b0;
  logic rst;

  bit sender_idling = 1'b1;
  bit sink_idling = 1'b1;
  bit hold_off_req = 1'b0;
  int idle_cycles;

  int fail_count;
  int pending_digits;
  int values_seen;
  int digits_seen;
  int full_runs;

  logic [31:0] directed_values[$] = '{
    32'd0, 32'd1, 32'd7, 32'd9, 32'd10, 32'd99, 32'd100, 32'd12345,
    32'd10203040, 32'd999999999, 32'd1000000000, 32'd1000000001,
    32'd2147483647, 32'd2147483648, 32'd3999999999, 32'd4000000000,
    32'h5555_5555, 32'hAAAA_AAAA, 32'd4294967294, 32'd4294967295
  };

  b2d_in_if  din_bus ();
  b2d_out_if dout_bus ();

  binary_to_decimal_ascii #(
    .VALUE_BITS(VALUE_BITS)
  ) dut (
    .clk (clk),
    .rst (rst),
    .din (din_bus),
    .dout(dout_bus)
  );

  decimal_digit_checker #(
    .VALUE_BITS(VALUE_BITS)
  ) checker_inst (
    .clk           (clk),
    .rst           (rst),
    .din           (din_bus),
    .dout          (dout_bus),
    .fail_count    (fail_count),
    .pending_digits(pending_digits),
    .values_seen   (values_seen),
    .digits_seen   (digits_seen),
    .full_runs     (full_runs)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // offer one value and hold it until the transfer happens
  task automatic send_value(input logic [31:0] v);
    if (sender_idling && $urandom_range(0, 3) == 0) begin
      din_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    din_bus.valid <= 1'b1;
    din_bus.value <= v;
    do @(posedge clk); while (!din_bus.ready);
  endtask

  initial begin
    int unsigned span;
    logic [31:0] v;
    rst <= 1'b1;
    din_bus.valid <= 1'b0;
    din_bus.value <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_values[i]) send_value(directed_values[i]);

    hold_off_req = 1'b1;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS - QUIET_ITEMS) begin
        sender_idling = 1'b0;
        sink_idling = 1'b0;
      end
      case ($urandom_range(0, 9))
        0, 1, 2: v = $urandom;
        3, 4, 5, 6: begin
          span = 1;
          repeat ($urandom_range(1, 9)) span = span * RADIX;
          v = $urandom % span;
        end
        7: v = $urandom_range(0, 20);
        8: begin
          span = 1;
          repeat ($urandom_range(1, 9)) span = span * RADIX;
          v = span + $urandom_range(0, 2) - 1;
        end
        default: v = 32'hFFFF_FFFF - $urandom_range(0, 1000);
      endcase
      send_value(v);
    end
    din_bus.valid <= 1'b0;

    @(posedge clk);
    while (pending_digits != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d values (%0d of ten digits) and %0d digit transfers",
             values_seen, full_runs, digits_seen);
    $display("with random gaps on both sides and one %0d-cycle output hold-off",
             LONG_HOLD);
    if (fail_count == 0 && pending_digits == 0) begin
      $display("binary_to_decimal_ascii verification clean");
    end else begin
      $display("binary_to_decimal_ascii verification failed");
    end
    $finish;
  end

  // output side: random stalls, one long hold-off while input keeps offering
  initial begin
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        dout_bus.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (sink_idling && $urandom_range(0, 3) == 0) begin
        dout_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end else begin
        dout_bus.ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (din_bus.valid && din_bus.ready) || (dout_bus.valid && dout_bus.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (!rst && idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d digits outstanding",
               idle_cycles, pending_digits);
      $display("binary_to_decimal_ascii verification failed");
      $finish;
    end
  end

endmodule
